// ===== rtl/gse_pkg.sv =====
package gse_pkg;

  // Sample width follows the sample port; chunk width follows code_bits.
  localparam int SampleBits   = 16;
  localparam int MaxQuotient  = 1984;
  localparam int ChunkBits    = 32;
  localparam int DivisorBits  = 16;

  localparam int QuoBits      = $clog2(MaxQuotient + 1);
  localparam int DivRadixBits = 4;
  localparam int DivCycles    = (SampleBits + DivRadixBits - 1) / DivRadixBits;
  localparam int DvdBits      = DivCycles * DivRadixBits;
  localparam int DivCntBits   = (DivCycles > 1) ? $clog2(DivCycles) : 1;
  localparam int LogBits      = $clog2(DivisorBits + 1);
  localparam int CntBits      = $clog2(ChunkBits + 1);
  localparam int WideBits     = 2 * ChunkBits;
  localparam int ShiftBits    = $clog2(WideBits + 1);

  localparam int QueueDepth   = 2;
  localparam int QPtrBits     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [DivisorBits-1:0] DivisorReset = DivisorBits'(4);

  // register indexes
  localparam int RegDivisor = 0;

  typedef struct packed {
    logic                   err;
    logic [QuoBits-1:0]     quo;
    logic [DivisorBits-1:0] rval;
    logic [LogBits-1:0]     rlen;
  } code_desc_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_FIN
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_BODY,
    B_TAIL
  } back_state_e;

  // smallest k with 2^k >= m, m >= 1
  function automatic logic [LogBits-1:0] ceil_log2(input logic [DivisorBits-1:0] m);
    logic [DivisorBits-1:0] mm;
    logic [LogBits-1:0]     k;
    mm = m - DivisorBits'(1);
    k  = '0;
    for (int i = 0; i < DivisorBits; i++) begin
      if (mm[i]) k = LogBits'(i + 1);
    end
    return k;
  endfunction

endpackage

// ===== rtl/gse_front.sv =====
module gse_front import gse_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [15:0]            sample_i,
  input  logic [DivisorBits-1:0] divisor_i,
  output logic                   desc_valid_o,
  output code_desc_t             desc_o,
  input  logic                   desc_full_i
);

  front_state_e state_q, state_d;

  logic [DvdBits-1:0]     dvd_q, dvd_d;
  logic [DivisorBits-1:0] rem_q, rem_d;
  logic [DivisorBits-1:0] m_q;
  logic [LogBits-1:0]     k_q;
  logic [DivisorBits:0]   t_q;
  logic [DivCntBits-1:0]  cnt_q;

  logic                   accept;
  logic                   div_last;
  logic [SampleBits-1:0]  folded;
  logic [DivisorBits-1:0] m_in;
  logic [LogBits-1:0]     k_in;
  logic                   rem_small;

  assign accept   = push_i && !full_o;
  assign div_last = (cnt_q == DivCntBits'(DivCycles - 1));

  // zigzag fold: 2v, or 2|v|-1 for negatives
  assign folded = {sample_i[SampleBits-2:0], 1'b0} ^ {SampleBits{sample_i[SampleBits-1]}};
  assign m_in   = (divisor_i == '0) ? DivisorBits'(1) : divisor_i;
  assign k_in   = ceil_log2(m_in);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (push_i) state_d = F_DIV;
      F_DIV:   if (div_last) state_d = F_FIN;
      F_FIN:   if (!desc_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    full_o       = 1'b1;
    desc_valid_o = 1'b0;
    case (state_q)
      F_IDLE:  full_o = 1'b0;
      F_FIN:   desc_valid_o = 1'b1;
      default: ;
    endcase
  end

  // radix-16 restoring divide: four compare/subtract steps per cycle
  always_comb begin
    logic [DivisorBits:0] trial;
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int j = 0; j < DivRadixBits; j++) begin
      trial = {rem_d, dvd_d[DvdBits-1]};
      dvd_d = {dvd_d[DvdBits-2:0], 1'b0};
      if (trial >= {1'b0, m_q}) begin
        rem_d    = DivisorBits'(trial - {1'b0, m_q});
        dvd_d[0] = 1'b1;
      end else begin
        rem_d = trial[DivisorBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) cnt_q <= '0;
      else if (state_q == F_DIV) cnt_q <= cnt_q + DivCntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dvd_q <= DvdBits'(folded);
      rem_q <= '0;
      m_q   <= m_in;
      k_q   <= k_in;
      t_q   <= (DivisorBits+1)'((DivisorBits+1)'(1) << k_in) - {1'b0, m_in};
    end else if (state_q == F_DIV) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // truncated binary remainder
  assign rem_small = ({1'b0, rem_q} < t_q);

  always_comb begin
    desc_o.err  = (dvd_q > DvdBits'(MaxQuotient));
    desc_o.quo  = dvd_q[QuoBits-1:0];
    desc_o.rval = rem_small ? rem_q : DivisorBits'({1'b0, rem_q} + t_q);
    desc_o.rlen = rem_small ? (k_q - LogBits'(1)) : k_q;
  end

endmodule

// ===== rtl/gse_queue.sv =====
module gse_queue import gse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  input  code_desc_t wr_data_i,
  output logic       full_o,
  output logic       rd_valid_o,
  output code_desc_t rd_data_o,
  input  logic       rd_pop_i
);

  code_desc_t          mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrBits:0]   count_q;
  logic                do_wr, do_rd;

  assign full_o     = (count_q == (QPtrBits+1)'(QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  function automatic logic [QPtrBits-1:0] ptr_inc(input logic [QPtrBits-1:0] p);
    return (p == QPtrBits'(QueueDepth - 1)) ? '0 : p + QPtrBits'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_rd) rd_ptr_q <= ptr_inc(rd_ptr_q);
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + (QPtrBits+1)'(1);
        2'b01:   count_q <= count_q - (QPtrBits+1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== rtl/gse_back.sv =====
module gse_back import gse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 desc_valid_i,
  input  code_desc_t           desc_i,
  output logic                 desc_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [ChunkBits-1:0] code_bits_o,
  output logic [CntBits-1:0]   bit_count_o,
  output logic                 last_chunk_o,
  output logic                 too_long_o
);

  back_state_e state_q, state_d;

  logic [QuoBits-1:0]     ones_q;
  logic [DivisorBits-1:0] rval_q;
  logic [LogBits-1:0]     rlen_q;
  logic                   err_q;
  logic [ChunkBits-1:0]   tail_bits_q;
  logic [CntBits-1:0]     tail_cnt_q;

  logic                   out_valid_q;
  logic                   out_free;
  logic                   emit;
  logic [ChunkBits-1:0]   bits_d;
  logic [CntBits-1:0]     cnt_d;
  logic                   last_d, err_d;

  logic                   many_ones;
  logic [CntBits-1:0]     ones_lo;
  logic [CntBits:0]       n_bits;
  logic [ShiftBits-1:0]   sh;
  logic [WideBits-1:0]    word;
  logic                   fits;

  assign out_free  = !out_valid_q || pop_i;
  assign many_ones = (ones_q >= QuoBits'(ChunkBits));
  assign ones_lo   = ones_q[CntBits-1:0];
  // ones, then the zero stop bit and the remainder bits
  assign n_bits    = (CntBits+1)'(ones_lo) + (CntBits+1)'(rlen_q) + (CntBits+1)'(1);
  assign sh        = ShiftBits'(WideBits) - ShiftBits'(n_bits);
  assign word      = ~({WideBits{1'b1}} >> ones_lo) | (WideBits'(rval_q) << sh);
  assign fits      = (n_bits <= (CntBits+1)'(ChunkBits));

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (desc_valid_i) state_d = B_BODY;
      B_BODY: begin
        if (out_free) begin
          if (err_q) state_d = B_IDLE;
          else if (!many_ones) state_d = fits ? B_IDLE : B_TAIL;
        end
      end
      B_TAIL:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    desc_pop_o = 1'b0;
    emit       = 1'b0;
    bits_d     = '0;
    cnt_d      = '0;
    last_d     = 1'b0;
    err_d      = 1'b0;
    case (state_q)
      B_IDLE: desc_pop_o = desc_valid_i;
      B_BODY: begin
        emit = out_free;
        if (err_q) begin
          last_d = 1'b1;
          err_d  = 1'b1;
        end else if (many_ones) begin
          bits_d = '1;
          cnt_d  = CntBits'(ChunkBits);
        end else begin
          bits_d = word[WideBits-1 -: ChunkBits];
          cnt_d  = fits ? n_bits[CntBits-1:0] : CntBits'(ChunkBits);
          last_d = fits;
        end
      end
      B_TAIL: begin
        emit   = out_free;
        bits_d = tail_bits_q;
        cnt_d  = tail_cnt_q;
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_pop_o) begin
      ones_q <= desc_i.quo;
      rval_q <= desc_i.rval;
      rlen_q <= desc_i.rlen;
      err_q  <= desc_i.err;
    end else if (state_q == B_BODY && emit && many_ones) begin
      ones_q <= ones_q - QuoBits'(ChunkBits);
    end
    if (state_q == B_BODY && emit) begin
      tail_bits_q <= word[ChunkBits-1:0];
      tail_cnt_q  <= CntBits'(n_bits - (CntBits+1)'(ChunkBits));
    end
    if (emit) begin
      code_bits_o  <= bits_d;
      bit_count_o  <= cnt_d;
      last_chunk_o <= last_d;
      too_long_o   <= err_d;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

// ===== rtl/golomb_signed_encoder_core.sv =====
// channel  | handshake          | word
// ---------+--------------------+------------------------------------------
// sample   | push / full        | sample_i
// result   | pop / empty        | code_bits_o, bit_count_o, last_chunk_o, too_long_o
// config   | APB write / read   | divisor at byte address 0
//
// Front: accepts a sample, divides it (4 quotient bits per cycle) and hands the
// descriptor to a 2-deep queue, waiting while it is full, then takes the next one.
// Back: a load, then quotient/32 + 1 or + 2 chunks, one per cycle while popped.
// Front and back run concurrently; the slower of the two sets the rate.
// Async active-low reset clears control state; divisor resets to 4.
// full drops only when the front is idle; a full queue holds it high after the divide.
module golomb_signed_encoder_core import gse_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [15:0]            sample_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [31:0]            code_bits_o,
  output logic [5:0]             bit_count_o,
  output logic                   last_chunk_o,
  output logic                   too_long_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [DivisorBits-1:0] divisor_q;
  logic                   reg_hit;

  code_desc_t fq_wr_data, fq_rd_data;
  logic       fq_wr_valid, fq_full, fq_rd_valid, fq_pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'(RegDivisor));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DivisorReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      divisor_q <= pwdata[DivisorBits-1:0];
    end
  end

  assign prdata = reg_hit ? 32'(divisor_q) : '0;

  gse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .sample_i     (sample_i),
    .divisor_i    (divisor_q),
    .desc_valid_o (fq_wr_valid),
    .desc_o       (fq_wr_data),
    .desc_full_i  (fq_full)
  );

  gse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_wr_valid),
    .wr_data_i  (fq_wr_data),
    .full_o     (fq_full),
    .rd_valid_o (fq_rd_valid),
    .rd_data_o  (fq_rd_data),
    .rd_pop_i   (fq_pop)
  );

  gse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (fq_rd_valid),
    .desc_i       (fq_rd_data),
    .desc_pop_o   (fq_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .code_bits_o  (code_bits_o),
    .bit_count_o  (bit_count_o),
    .last_chunk_o (last_chunk_o),
    .too_long_o   (too_long_o)
  );

endmodule

// ===== bench/tb_golomb_signed_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_golomb_signed_encoder_core;
  import gse_pkg::*;

  localparam int MaxWords      = 64;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 16;
  localparam int WatchdogLimit = 3000;
  localparam int RandPerPhase  = 35;

  typedef struct packed {
    logic [31:0] bits;
    logic [5:0]  cnt;
    logic        last;
    logic        err;
  } chunk_t;

  typedef struct packed {
    logic [15:0] dvs;
    logic [15:0] smp;
    logic        typed;
    chunk_t      res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] sample_i;
  logic        empty;
  logic        pop;
  logic [31:0] code_bits_o;
  logic [5:0]  bit_count_o;
  logic        last_chunk_o;
  logic        too_long_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  golomb_signed_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .empty       (empty),
    .pop         (pop),
    .code_bits_o (code_bits_o),
    .bit_count_o (bit_count_o),
    .last_chunk_o(last_chunk_o),
    .too_long_o  (too_long_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the divisor register and the words still owed by the block
  logic [DivisorBits-1:0] div_model = DivisorReset;
  chunk_t                 code_word_q[$];

  logic   typed_pending = 1'b0;
  chunk_t typed_exp     = '0;
  bit     hold_req      = 1'b0;
  int     tx_gap_pct    = 0;
  int     rx_stall_pct  = 0;

  int errors    = 0;
  int n_samples = 0;
  int n_words   = 0;
  int n_ovf     = 0;
  int n_writes  = 0;
  int idle_cnt  = 0;

  // directed words: expectation typed in where obvious, else from the encoder model
  dir_row_t dir_tab [22] = '{
    '{16'd4,     16'h0000, 1'b1, {32'h0000_0000, 6'd3,  1'b1, 1'b0}},
    '{16'd4,     16'h0001, 1'b1, {32'h4000_0000, 6'd3,  1'b1, 1'b0}},
    '{16'd4,     16'hFFFF, 1'b1, {32'h2000_0000, 6'd3,  1'b1, 1'b0}},
    '{16'd4,     16'h7FFF, 1'b1, {32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{16'd4,     16'h8000, 1'b1, {32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{16'd4,     16'd3968, 1'b0, '0},  // quotient right at the limit
    '{16'd4,     16'd3970, 1'b1, {32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{16'd1,     16'h0000, 1'b1, {32'h0000_0000, 6'd1,  1'b1, 1'b0}},
    '{16'd1,     16'h0001, 1'b1, {32'hC000_0000, 6'd3,  1'b1, 1'b0}},
    '{16'd1,     16'd992,  1'b0, '0},
    '{16'd1,     16'hFC1F, 1'b1, {32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{16'd0,     16'h0005, 1'b1, {32'hFFC0_0000, 6'd11, 1'b1, 1'b0}},
    '{16'd0,     16'hFFFF, 1'b1, {32'h8000_0000, 6'd2,  1'b1, 1'b0}},
    '{16'd3,     16'h0000, 1'b0, '0},
    '{16'd3,     16'h0001, 1'b0, '0},
    '{16'd3,     16'hFFFF, 1'b0, '0},
    '{16'd5,     16'h0007, 1'b0, '0},
    '{16'd5,     16'hFFFD, 1'b0, '0},
    '{16'd65535, 16'h8000, 1'b1, {32'h8000_0000, 6'd17, 1'b1, 1'b0}},
    '{16'd65535, 16'h7FFF, 1'b1, {32'h7FFF_8000, 6'd17, 1'b1, 1'b0}},
    '{16'd32768, 16'h8000, 1'b0, '0},
    '{16'd7,     16'd100,  1'b0, '0}
  };

  // fold, divide, unary quotient + truncated binary remainder, cut into words
  function automatic void golomb_encode(input logic [15:0] smp);
    int     v, u, m, q, r, k, t, rval, rlen, total;
    logic   b;
    chunk_t c;
    v = int'($signed(smp));
    u = (v >= 0) ? 2 * v : -2 * v - 1;
    m = (div_model == '0) ? 1 : int'(div_model);
    q = u / m;
    r = u % m;
    k = 0;
    while ((1 << k) < m) k++;
    t = (1 << k) - m;
    if (r < t) begin
      rval = r;
      rlen = k - 1;
    end else begin
      rval = r + t;
      rlen = k;
    end
    total = q + 1 + rlen;
    if (q > MaxQuotient || (total + ChunkBits - 1) / ChunkBits > MaxWords) begin
      code_word_q.push_back({32'h0, 6'd0, 1'b1, 1'b1});
      return;
    end
    c = '0;
    for (int i = 0; i < total; i++) begin
      if (i < q) b = 1'b1;
      else if (i == q) b = 1'b0;
      else b = 1'((rval >> (rlen - 1 - (i - q - 1))) & 1);
      c.bits[ChunkBits - 1 - int'(c.cnt)] = b;
      c.cnt++;
      if (int'(c.cnt) == ChunkBits || i == total - 1) begin
        c.last = (i == total - 1);
        code_word_q.push_back(c);
        c = '0;
      end
    end
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  // mostly samples whose quotient lands in a useful range, plus raw noise
  function automatic logic [15:0] pick_sample();
    int m, q, u, v;
    m = (div_model == '0) ? 1 : int'(div_model);
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom);
      3: begin
        case ($urandom_range(0, 4))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFF;
          3: return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
      default: begin
        q = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1990) : $urandom_range(0, 40);
        u = q * m + $urandom_range(0, m - 1);
        if (u > 65535) u = 65535;
        v = (u % 2 == 0) ? u / 2 : -(u + 1) / 2;
        return 16'(v);
      end
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] s, input int gap, input logic is_typed,
                             input chunk_t res);
    if (gap > 0) begin
      @(negedge clk_i) push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    typed_pending = is_typed;
    typed_exp     = res;
    push     <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // divisor changes only with the block drained, then read back
  task automatic set_divisor(input logic [31:0] val);
    @(negedge clk_i) push <= 1'b0;
    wait (code_word_q.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(RegDivisor * 4);
    pwdata  <= val;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {16'h0, val[15:0]}) begin
      $error("prdata: expected %h, got %h", {16'h0, val[15:0]}, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // monitor: prediction on accept, in-order word check, config shadow, watchdog
  always @(posedge clk_i) begin : mon
    chunk_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        div_model = pwdata[DivisorBits-1:0];
        n_writes++;
      end
      if (push && !full) begin
        if (typed_pending) begin
          code_word_q.push_back(typed_exp);
          typed_pending = 1'b0;
        end else begin
          golomb_encode(sample_i);
        end
        n_samples++;
      end
      if (pop && !empty) begin
        n_words++;
        if (too_long_o === 1'b1) n_ovf++;
        if (code_word_q.size() == 0) begin
          $error("word with nothing expected: code_bits %h bit_count %0d", code_bits_o,
                 bit_count_o);
          errors++;
        end else begin
          want = code_word_q.pop_front();
          if (code_bits_o !== want.bits) begin
            $error("code_bits: expected %h, got %h", want.bits, code_bits_o);
            errors++;
          end
          if (bit_count_o !== want.cnt) begin
            $error("bit_count: expected %0d, got %0d", want.cnt, bit_count_o);
            errors++;
          end
          if (last_chunk_o !== want.last) begin
            $error("last_chunk: expected %b, got %b", want.last, last_chunk_o);
            errors++;
          end
          if (too_long_o !== want.err) begin
            $error("too_long: expected %b, got %b", want.err, too_long_o);
            errors++;
          end
        end
      end
      if ((push && !full) || (pop && !empty) || (psel && penable && pready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WatchdogLimit) begin
        $display("tb_golomb_signed_encoder_core: done, errors");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        n = stall_len();
        pop <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] dv;
    rst_ni   = 1'b0;
    push     = 1'b0;
    sample_i = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].dvs != div_model) set_divisor({16'h0, dir_tab[i].dvs});
      send_sample(dir_tab[i].smp, ($urandom_range(0, 99) < tx_gap_pct) ? stall_len() : 0,
                  dir_tab[i].typed, dir_tab[i].res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: dv = 32'h0000_0001;
        1: dv = 32'hFFFF_0000;  // register reads 0, behaves as 1
        2: dv = {16'($urandom), 16'hFFFF};
        3: dv = {16'($urandom), 16'(1 << $urandom_range(1, 15))};
        4: dv = {16'($urandom), 16'($urandom_range(2, 20))};
        default: dv = {16'($urandom), 16'($urandom_range(1, 65535))};
      endcase
      set_divisor(dv);
      tx_gap_pct   = (ph == 0) ? 0 : $urandom_range(10, 50);
      rx_stall_pct = (ph == 0) ? 0 : $urandom_range(10, 50);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < RandPerPhase; i++) begin
        if (ph == 3 && i == RandPerPhase / 2) begin
          // sender waits for the block to run dry
          @(negedge clk_i) push <= 1'b0;
          wait (code_word_q.size() == 0);
        end
        send_sample(pick_sample(), ($urandom_range(0, 99) < tx_gap_pct) ? stall_len() : 0,
                    1'b0, '0);
      end
    end

    @(negedge clk_i) push <= 1'b0;
    wait (code_word_q.size() == 0);
    repeat (30) @(negedge clk_i);
    $display("run covered %0d samples and %0d result words (%0d too-long)", n_samples,
             n_words, n_ovf);
    $display("divisor writes: %0d, incl. 0, 1, 65535, powers of two, small and random",
             n_writes);
    if (errors == 0) begin
      $display("tb_golomb_signed_encoder_core: done, clean");
    end else begin
      $display("tb_golomb_signed_encoder_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gse_pkg.sv
rtl/gse_front.sv
rtl/gse_queue.sv
rtl/gse_back.sv
rtl/golomb_signed_encoder_core.sv
bench/tb_golomb_signed_encoder_core.sv
